// File: sv/cvc_pkg.sv
// Package for the coffee vending controller: phase enums, register indexes,
// coin codes, and the state, configuration, item and result structs.
// No dependencies; every other file of the block imports it.
package cvc_pkg;

  localparam int unsigned CreditW = 12;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned CoinW   = 8;

  localparam logic [CreditW-1:0] CreditMax = 12'd4095;

  typedef enum logic [1:0] {
    BREW_WAIT   = 2'd0,
    BREW_CUP    = 2'd1,
    BREW_COFFEE = 2'd2,
    BREW_MILK   = 2'd3
  } brew_phase_e;

  typedef enum logic {
    CASH_COLLECT = 1'b0,
    CASH_CHANGE  = 1'b1
  } cash_phase_e;

  typedef enum logic [1:0] {
    CFG_PRICE        = 2'd0,
    CFG_CUP_STEPS    = 2'd1,
    CFG_COFFEE_STEPS = 2'd2,
    CFG_MILK_STEPS   = 2'd3
  } cfg_idx_e;

  // Input coin type codes.
  localparam logic [2:0] COIN_5C   = 3'd0;
  localparam logic [2:0] COIN_10C  = 3'd1;
  localparam logic [2:0] COIN_20C  = 3'd2;
  localparam logic [2:0] COIN_50C  = 3'd3;
  localparam logic [2:0] COIN_100C = 3'd4;
  localparam logic [2:0] COIN_200C = 3'd5;

  // Change pulse codes on the result.
  localparam logic [2:0] CHG_NONE = 3'd0;
  localparam logic [2:0] CHG_5C   = 3'd1;
  localparam logic [2:0] CHG_10C  = 3'd2;
  localparam logic [2:0] CHG_20C  = 3'd3;
  localparam logic [2:0] CHG_50C  = 3'd4;
  localparam logic [2:0] CHG_100C = 3'd5;
  localparam logic [2:0] CHG_200C = 3'd6;

  typedef struct packed {
    logic [CreditW-1:0] price;
    logic [TimerW-1:0]  cup_steps;
    logic [TimerW-1:0]  coffee_steps;
    logic [TimerW-1:0]  milk_steps;
  } cvc_cfg_t;

  typedef struct packed {
    brew_phase_e        brew_phase;
    cash_phase_e        cash_phase;
    logic [CreditW-1:0] credit;
    logic               button_pending;
    logic               enough_pending;
    logic               paid;
    logic               charge;
    logic [TimerW-1:0]  timer;
  } cvc_state_t;

  typedef struct packed {
    logic [2:0] coin_code;
    logic       coin_event;
    logic       button_event;
  } cvc_item_t;

  typedef struct packed {
    logic [CreditW-1:0] credit_now;
    logic [2:0]         change_pulse;
    logic               ready_lamp;
    logic               milk_on;
    logic               coffee_on;
    logic               cup_on;
  } cvc_result_t;

  // Value in cents of an input coin code; unknown codes are worth nothing.
  function automatic logic [CoinW-1:0] coin_value(input logic [2:0] code);
    logic [CoinW-1:0] v;
    case (code)
      COIN_5C:   v = 8'd5;
      COIN_10C:  v = 8'd10;
      COIN_20C:  v = 8'd20;
      COIN_50C:  v = 8'd50;
      COIN_100C: v = 8'd100;
      COIN_200C: v = 8'd200;
      default:   v = 8'd0;
    endcase
    return v;
  endfunction

  // A step count of zero behaves like one.
  function automatic logic [TimerW-1:0] load_steps(input logic [TimerW-1:0] n);
    return (n == '0) ? TimerW'(1) : n;
  endfunction

endpackage

// File: sv/cvc_cfg_regs.sv
// Configuration register file of the coffee vending controller.
// Depends on cvc_pkg for the register index enum and the config struct.
module cvc_cfg_regs
  import cvc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [1:0] wr_index_i,
  input  logic [15:0] wr_data_i,
  output cvc_cfg_t   cfg_o
);

  cvc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CFG_PRICE:        cfg_d.price        = wr_data_i[CreditW-1:0];
        CFG_CUP_STEPS:    cfg_d.cup_steps    = wr_data_i;
        CFG_COFFEE_STEPS: cfg_d.coffee_steps = wr_data_i;
        CFG_MILK_STEPS:   cfg_d.milk_steps   = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.price        <= 12'd50;
      cfg_q.cup_steps    <= 16'd1;
      cfg_q.coffee_steps <= 16'd12;
      cfg_q.milk_steps   <= 16'd12;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/cvc_step.sv
// Combinational step logic: latches the button and coin, advances the brew
// machine and then the money machine. Depends on cvc_pkg.
module cvc_step
  import cvc_pkg::*;
(
  input  cvc_state_t  state_i,
  input  cvc_cfg_t    cfg_i,
  input  cvc_item_t   item_i,
  output cvc_state_t  state_o,
  output cvc_result_t result_o
);

  logic [CreditW:0]   credit_sum;
  logic               expired;
  logic [2:0]         pulse;

  assign credit_sum = {1'b0, state_i.credit} + {{(CreditW+1-CoinW){1'b0}},
                                                coin_value(item_i.coin_code)};
  assign expired    = (state_i.timer[TimerW-1:1] == '0);

  // Next state, in the order button/coin, brew, money.
  always_comb begin
    state_o = state_i;
    pulse   = CHG_NONE;

    if (item_i.button_event) begin
      state_o.button_pending = 1'b1;
    end
    if (item_i.coin_event) begin
      state_o.credit = credit_sum[CreditW] ? CreditMax : credit_sum[CreditW-1:0];
      if (state_o.credit >= cfg_i.price) begin
        state_o.enough_pending = 1'b1;
      end
    end

    unique case (state_i.brew_phase)
      BREW_WAIT: begin
        if (state_o.button_pending && state_o.paid) begin
          state_o.button_pending = 1'b0;
          state_o.paid           = 1'b0;
          state_o.brew_phase     = BREW_CUP;
          state_o.timer          = load_steps(cfg_i.cup_steps);
        end
      end
      BREW_CUP: begin
        if (expired) begin
          state_o.brew_phase = BREW_COFFEE;
          state_o.timer      = load_steps(cfg_i.coffee_steps);
        end else begin
          state_o.timer = state_i.timer - TimerW'(1);
        end
      end
      BREW_COFFEE: begin
        if (expired) begin
          state_o.brew_phase = BREW_MILK;
          state_o.timer      = load_steps(cfg_i.milk_steps);
        end else begin
          state_o.timer = state_i.timer - TimerW'(1);
        end
      end
      BREW_MILK: begin
        if (expired) begin
          state_o.brew_phase = BREW_WAIT;
          state_o.timer      = '0;
          // A price raised during the brew clips the charge at zero credit.
          state_o.credit     = (state_o.credit >= cfg_i.price) ?
                               state_o.credit - cfg_i.price : '0;
          state_o.charge     = 1'b1;
        end else begin
          state_o.timer = state_i.timer - TimerW'(1);
        end
      end
      default: ;
    endcase

    if (state_i.cash_phase == CASH_COLLECT) begin
      if (state_o.enough_pending) begin
        state_o.enough_pending = 1'b0;
        state_o.paid           = 1'b1;
        state_o.cash_phase     = CASH_CHANGE;
      end
    end else if (state_o.charge) begin
      // Greedy change: the largest coin that still fits, one per step.
      if (state_o.credit >= 12'd200) begin
        pulse = CHG_200C;
        state_o.credit = state_o.credit - 12'd200;
      end else if (state_o.credit >= 12'd100) begin
        pulse = CHG_100C;
        state_o.credit = state_o.credit - 12'd100;
      end else if (state_o.credit >= 12'd50) begin
        pulse = CHG_50C;
        state_o.credit = state_o.credit - 12'd50;
      end else if (state_o.credit >= 12'd20) begin
        pulse = CHG_20C;
        state_o.credit = state_o.credit - 12'd20;
      end else if (state_o.credit >= 12'd10) begin
        pulse = CHG_10C;
        state_o.credit = state_o.credit - 12'd10;
      end else if (state_o.credit >= 12'd5) begin
        pulse = CHG_5C;
        state_o.credit = state_o.credit - 12'd5;
      end
      // A remainder below five cents cannot be paid out and stays as credit.
      if (state_o.credit < 12'd5) begin
        state_o.charge     = 1'b0;
        state_o.cash_phase = CASH_COLLECT;
      end
    end
  end

  // Outputs decoded from the phase after this step.
  always_comb begin
    result_o.cup_on       = (state_o.brew_phase == BREW_CUP);
    result_o.coffee_on    = (state_o.brew_phase == BREW_COFFEE);
    result_o.milk_on      = (state_o.brew_phase == BREW_MILK);
    result_o.ready_lamp   = (state_o.brew_phase == BREW_WAIT);
    result_o.change_pulse = pulse;
    result_o.credit_now   = state_o.credit;
  end

endmodule

// File: sv/coffee_vending_controller.sv
// Top level of the coffee vending controller: input register, step logic,
// state and result registers. Depends on cvc_pkg, cvc_cfg_regs and cvc_step.
//
// Usage. Each request on the slave stream is one machine step carrying a
// button press, a coin flag and a coin type code. Every request yields exactly
// one result on the master stream with the valve and cup outputs, the ready
// lamp, the change coin returned in that step and the credit after the step.
// The configuration channel writes the price and the three step counts; it is
// always ready and must only be used while no request is in flight.
//
// Pipeline and throughput. A request is captured in the input register; when
// the result register is free or draining, the single-pass step logic
// updates the machine state and loads the result register. One request is
// taken every cycle for as long as the receiver keeps up; the rate is set by
// the one state update per cycle.
//
// Stalls and reset. When the receiver holds tready low, the result stays in
// the output register and one more request can still be taken into the input
// register before tready drops on the slave side. Reset clears the machine to
// waiting and collecting with zero credit and loads the register defaults:
// price 50, cup 1 step, coffee and milk 12 steps each.
module coffee_vending_controller
  import cvc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream, one request per machine step.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: [0] button_event, [1] coin_event, [4:2] coin_code, [7:5] zero
  input  logic [7:0]  s_axis_tdata_i,
  // Master stream, one result per step.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: [0] cup_on, [1] coffee_on, [2] milk_on, [3] ready_lamp,
  //        [6:4] change_pulse, [18:7] credit_now, [23:19] zero
  output logic [23:0] m_axis_tdata_o,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  cvc_cfg_t    cfg;
  cvc_item_t   in_q;
  logic        in_valid_q;
  cvc_state_t  state_q, state_d;
  cvc_result_t result_d, result_q;
  logic        out_valid_q;
  logic        advance;

  // Configuration registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  cvc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The held request moves on when the result register is free or draining.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q.button_event <= s_axis_tdata_i[0];
      in_q.coin_event   <= s_axis_tdata_i[1];
      in_q.coin_code    <= s_axis_tdata_i[4:2];
    end
  end

  cvc_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // Machine state advances once per request that moves into the result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.brew_phase     <= BREW_WAIT;
      state_q.cash_phase     <= CASH_COLLECT;
      state_q.credit         <= '0;
      state_q.button_pending <= 1'b0;
      state_q.enough_pending <= 1'b0;
      state_q.paid           <= 1'b0;
      state_q.charge         <= 1'b0;
      state_q.timer          <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, result_q.credit_now, result_q.change_pulse,
                            result_q.ready_lamp, result_q.milk_on,
                            result_q.coffee_on, result_q.cup_on};

  // Exactly one brew phase output is active in every result.
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot({result_q.cup_on, result_q.coffee_on,
                             result_q.milk_on, result_q.ready_lamp}))
    else $error("brew phase outputs not one-hot");

  // Change is paid out only after the brew has finished.
  a_change_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.change_pulse != CHG_NONE) |-> result_q.ready_lamp)
    else $error("change returned while brewing");

  // A running brew phase always has a live step timer.
  a_timer_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.brew_phase != BREW_WAIT) |-> (state_q.timer != '0))
    else $error("brew phase active with a zero step timer");

  // State changes only when a request moves into the result stage.
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("machine state changed without a request");

endmodule
